[rtl/pfa_pkg.sv]
// Package for the partition fit allocator: payload structs, status and policy codes,
// and the scan and write-back structs shared by the top level and the table cells.
// It depends on nothing else.
package pfa_pkg;

	localparam int PICK_W  = 6;
	localparam int COUNT_W = 7;
	localparam int SUM_W   = 14;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic       CMD_ALLOC   = 1'b0;
	localparam logic       CMD_RELEASE = 1'b1;

	localparam logic       CFG_FIT_POLICY = 1'b0;
	localparam logic       CFG_CAPACITY   = 1'b1;

	localparam logic [7:0] CAPACITY_RESET = 8'd56;

	localparam logic [2:0] ST_PLACED    = 3'd0;
	localparam logic [2:0] ST_APPENDED  = 3'd1;
	localparam logic [2:0] ST_FAILED    = 3'd2;
	localparam logic [2:0] ST_RELEASED  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_LAUNCH,
		FSM_SCAN
	} fsm_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] pid;
		logic [7:0] request_size;
	} request_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] part_index;
		logic [7:0] part_size;
	} result_t;

	typedef struct packed {
		logic               found;
		logic [PICK_W-1:0]  pick;
		logic [7:0]         pick_size;
		logic [SUM_W-1:0]   sum;
	} scan_acc_t;

	typedef struct packed {
		logic               cmd;
		logic [7:0]         pid;
		logic [7:0]         req;
		logic [1:0]         policy;
		logic [COUNT_W-1:0] count;
	} scan_op_t;

	typedef struct packed {
		logic              en;
		logic [PICK_W-1:0] idx;
		logic [7:0]        owner;
		logic [7:0]        size;
		logic [7:0]        occupied;
		logic              set_size;
	} wr_cmd_t;

endpackage

[rtl/pfa_cell.sv]
// One table cell of the partition fit allocator: it holds one partition entry and
// updates the scan record that passes through it on its way along the chain.
// It depends on pfa_pkg.
module pfa_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfa_pkg::scan_op_t op,
	input  pfa_pkg::wr_cmd_t  wr,
	input  logic              tok_in,
	input  pfa_pkg::scan_acc_t acc_in,
	output logic              tok_out,
	output pfa_pkg::scan_acc_t acc_out
);

	localparam logic [pfa_pkg::PICK_W-1:0]  MY_IDX   = pfa_pkg::PICK_W'(CELL_IDX);
	localparam logic [pfa_pkg::COUNT_W-1:0] MY_COUNT = pfa_pkg::COUNT_W'(CELL_IDX);

	logic [7:0]          owner_q;
	logic [7:0]          size_q;
	logic [7:0]          occupied_q;
	logic                tok_q;
	pfa_pkg::scan_acc_t  acc_q;
	pfa_pkg::scan_acc_t  acc_nx;
	logic                active;
	logic                take;

	assign active = MY_COUNT < op.count;

	always_comb begin
		acc_nx = acc_in;
		take   = 1'b0;
		if (active) begin
			acc_nx.sum = acc_in.sum + pfa_pkg::SUM_W'(size_q);
			if (op.cmd == pfa_pkg::CMD_RELEASE) begin
				take = !acc_in.found && (owner_q == op.pid);
			end else if (owner_q == 8'd0 && size_q >= op.req) begin
				if (!acc_in.found) begin
					take = 1'b1;
				end else if (op.policy == pfa_pkg::FIT_BEST) begin
					take = size_q < acc_in.pick_size;
				end else if (op.policy == pfa_pkg::FIT_WORST) begin
					take = size_q > acc_in.pick_size;
				end
			end
		end
		if (take) begin
			acc_nx.found     = 1'b1;
			acc_nx.pick      = MY_IDX;
			acc_nx.pick_size = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_nx;
		if (wr.en && wr.idx == MY_IDX) begin
			owner_q    <= wr.owner;
			occupied_q <= wr.occupied;
			if (wr.set_size) begin
				size_q <= wr.size;
			end
		end
	end

	assign tok_out = tok_q;
	assign acc_out = acc_q;

endmodule

[rtl/partition_fit_allocator_core.sv]
// Top level of the partition fit allocator: request control, configuration registers,
// the chain of table cells and the result register.
// It depends on pfa_pkg and pfa_cell.

// A request is taken when start is high and busy is low; its result appears on result
// with done high for one cycle, and busy falls in that same cycle. A new request is
// taken only once busy is low again. The scan record walks the chain of table cells,
// one cell per cycle, followed by the decision and write-back, which register the
// result and update the table; the result is then shown while the block is idle.
// The receiver cannot hold a result off, so done must be sampled when it is high.
module partition_fit_allocator_core #(
	parameter int MAX_PARTITIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pfa_pkg::request_t request,
	output logic              done,
	output pfa_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	pfa_pkg::fsm_t                 state_q;
	pfa_pkg::fsm_t                 state_nx;
	pfa_pkg::request_t             req_q;
	logic [1:0]                    fit_policy_q;
	logic [7:0]                    capacity_q;
	logic [pfa_pkg::COUNT_W-1:0]   count_q;
	logic [pfa_pkg::COUNT_W-1:0]   count_nx;
	logic                          done_q;
	pfa_pkg::result_t              result_q;
	pfa_pkg::result_t              result_nx;
	logic                          finish;
	pfa_pkg::scan_op_t             op;
	pfa_pkg::wr_cmd_t              wr;
	logic                          tok_chain [0:MAX_PARTITIONS];
	pfa_pkg::scan_acc_t            acc_chain [0:MAX_PARTITIONS];
	pfa_pkg::scan_acc_t            acc_last;
	logic [pfa_pkg::SUM_W:0]       total;

	assign busy = state_q != pfa_pkg::FSM_IDLE;

	assign op.cmd    = req_q.cmd;
	assign op.pid    = req_q.pid;
	assign op.req    = req_q.request_size;
	assign op.policy = fit_policy_q;
	assign op.count  = count_q;

	assign tok_chain[0] = state_q == pfa_pkg::FSM_LAUNCH;
	assign acc_chain[0] = '0;

	for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
		pfa_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.wr     (wr),
			.tok_in (tok_chain[i]),
			.acc_in (acc_chain[i]),
			.tok_out(tok_chain[i+1]),
			.acc_out(acc_chain[i+1])
		);
	end

	assign acc_last = acc_chain[MAX_PARTITIONS];
	assign total    = {1'b0, acc_last.sum} + (pfa_pkg::SUM_W + 1)'(req_q.request_size);

	always_comb begin
		state_nx  = state_q;
		finish    = 1'b0;
		unique case (state_q)
			pfa_pkg::FSM_IDLE: begin
				if (start) begin
					state_nx = pfa_pkg::FSM_LAUNCH;
				end
			end
			pfa_pkg::FSM_LAUNCH: begin
				state_nx = pfa_pkg::FSM_SCAN;
			end
			pfa_pkg::FSM_SCAN: begin
				if (tok_chain[MAX_PARTITIONS]) begin
					finish   = 1'b1;
					state_nx = pfa_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_nx = pfa_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		wr        = '0;
		count_nx  = count_q;
		result_nx = '0;
		if (req_q.cmd == pfa_pkg::CMD_RELEASE) begin
			if (acc_last.found) begin
				wr.en                = finish;
				wr.idx               = acc_last.pick;
				result_nx.status     = pfa_pkg::ST_RELEASED;
				result_nx.part_index = acc_last.pick[3:0];
				result_nx.part_size  = acc_last.pick_size;
			end else begin
				result_nx.status = pfa_pkg::ST_NOT_FOUND;
			end
		end else if (acc_last.found) begin
			wr.en                = finish;
			wr.idx               = acc_last.pick;
			wr.owner             = req_q.pid;
			wr.occupied          = req_q.request_size;
			result_nx.status     = pfa_pkg::ST_PLACED;
			result_nx.part_index = acc_last.pick[3:0];
			result_nx.part_size  = acc_last.pick_size;
		end else if (count_q < pfa_pkg::COUNT_W'(MAX_PARTITIONS)
				&& total <= (pfa_pkg::SUM_W + 1)'(capacity_q)) begin
			wr.en                = finish;
			wr.idx               = count_q[pfa_pkg::PICK_W-1:0];
			wr.owner             = req_q.pid;
			wr.size              = req_q.request_size;
			wr.occupied          = req_q.request_size;
			wr.set_size          = 1'b1;
			count_nx             = count_q + pfa_pkg::COUNT_W'(1);
			result_nx.status     = pfa_pkg::ST_APPENDED;
			result_nx.part_index = count_q[3:0];
			result_nx.part_size  = req_q.request_size;
		end else begin
			result_nx.status = pfa_pkg::ST_FAILED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pfa_pkg::FSM_IDLE;
			count_q      <= '0;
			done_q       <= 1'b0;
			fit_policy_q <= pfa_pkg::FIT_FIRST;
			capacity_q   <= pfa_pkg::CAPACITY_RESET;
		end else begin
			state_q <= state_nx;
			done_q  <= finish;
			if (finish) begin
				count_q <= count_nx;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					pfa_pkg::CFG_FIT_POLICY: fit_policy_q <= cfg_data[1:0];
					pfa_pkg::CFG_CAPACITY:   capacity_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		if (finish) begin
			result_q <= result_nx;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/pfa_checker.sv]
// Port-level checker for the partition fit allocator and the bind that attaches it.
// It depends on pfa_pkg and partition_fit_allocator_core.
module pfa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input pfa_pkg::result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted transaction did not raise busy.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while still busy.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == pfa_pkg::ST_FAILED
			|| result.status == pfa_pkg::ST_NOT_FOUND)
		|-> result.part_index == 4'd0 && result.part_size == 8'd0)
		else $error("Failed transaction reported a nonzero partition.");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= pfa_pkg::ST_NOT_FOUND)
		else $error("Result status out of range.");

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
